### hw/rtl/cbs_pkg.sv
// Shared types, codes and constants for the cubic B-spline evaluator.
// No dependencies.
package cbs_pkg;

  // Command codes on the input channel
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_EVAL   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Status codes on the result channel
  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_EVAL   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  // Point counter width, fixed by the period_count field
  localparam int TOTAL_W = 13;

  // Divide-by-three unit: 40-bit dividend, one byte per step
  localparam int DIV_W     = 40;
  localparam int DIV_STEPS = DIV_W / 8;
  // Offset (a multiple of three) that makes every dividend non-negative
  localparam logic [DIV_W-1:0] DIV_OFS = 40'h18_0000_0000;

  typedef logic [DIV_W-1:0] dvd_t;
  typedef logic signed [31:0] coord_t;

  // One byte step of long division by 3: {rem, byte} / 3
  function automatic logic [7:0] div3_quo(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  function automatic logic [1:0] div3_rem(input logic [9:0] x);
    logic [9:0] r;
    r = x - 10'(div3_quo(x)) * 10'd3;
    return r[1:0];
  endfunction

endpackage

### hw/rtl/cbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/cubic_bspline_eval_2d_top.sv
// Uniform cubic B-spline evaluator over up to MAX_POINTS stored 2D points
// (signed Q16.16). Append, clear, unused and rejected items answer in the
// cycle after acceptance. An evaluate item passes through these steps: read the
// four clamped points from the point memories (one read port each, x and y in
// parallel), form the Bezier numerators, five byte steps of the divide-by-three
// units, three levels of de Casteljau interpolation (each a multiply, then a
// round and add), and load the result once the result slot is free.
// One item is in work at a time.
// Depends on cbs_pkg and cbs_ram.
module cubic_bspline_eval_2d_top import cbs_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic [11:0]        t_segment,
  input  logic [15:0]        t_fraction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] curve_x,
  output logic signed [31:0] curve_y,
  output logic [1:0]         status,
  output logic [12:0]        period_count
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam logic [TOTAL_W-1:0] MAX_CNT = TOTAL_W'(MAX_POINTS);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_PREP, S_DIV, S_MUL, S_ADD, S_DONE
  } state_t;

  state_t              state;
  logic [TOTAL_W-1:0]  total;
  logic [11:0]         seg;
  logic [15:0]         u;
  logic [2:0]          cnt;
  logic [1:0]          lvl;
  coord_t              qx [4];
  coord_t              qy [4];
  coord_t              bx [4];
  coord_t              by [4];
  dvd_t                dvd [8];
  logic [1:0]          rem [8];
  logic [31:0]         quo [8];
  logic signed [49:0]  prx [3];
  logic signed [49:0]  pry [3];

  logic                accept, wr_en, slot_free, eval_bad, res_load;
  logic [AW-1:0]       raddr;
  logic [31:0]         rd_x, rd_y;
  logic [TOTAL_W-1:0]  total_after;
  logic [1:0]          slot;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign wr_en     = accept && (command == CMD_APPEND) && (total != MAX_CNT);
  assign eval_bad  = (total == '0) || (TOTAL_W'(t_segment) > total + TOTAL_W'(2));
  assign slot      = 2'(cnt - 3'd1);

  // A result is loaded on an immediate answer or at the end of an evaluation
  assign res_load  = (state == S_IDLE && accept && !(command == CMD_EVAL && !eval_bad))
                  || (state == S_DONE && slot_free);

  // Point memories
  cbs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk(clk), .we(wr_en), .waddr(total[AW-1:0]), .wdata(point_x),
    .raddr(raddr), .rdata(rd_x)
  );
  cbs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk(clk), .we(wr_en), .waddr(total[AW-1:0]), .wdata(point_y),
    .raddr(raddr), .rdata(rd_y)
  );

  // Clamped read address of padded point seg + cnt
  always_comb begin
    logic [TOTAL_W-1:0] p, pm;
    p  = TOTAL_W'(seg) + TOTAL_W'(cnt[1:0]);
    pm = p - TOTAL_W'(3);
    if (p < TOTAL_W'(3)) begin
      raddr = '0;
    end else if (pm >= total) begin
      pm    = total - TOTAL_W'(1);
      raddr = pm[AW-1:0];
    end else begin
      raddr = pm[AW-1:0];
    end
  end

  // Count after the item acts, for the result
  always_comb begin
    total_after = total;
    if (wr_en) begin
      total_after = total + TOTAL_W'(1);
    end else if (accept && command == CMD_CLEAR) begin
      total_after = '0;
    end
  end

  // Bezier numerator, rounded and offset for the divide-by-three unit
  function automatic dvd_t div_in(input coord_t q0, input coord_t q1,
                                  input coord_t q2, input coord_t q3,
                                  input logic [1:0] which);
    logic signed [DIV_W-1:0] a0, a1, a2, a3, n, m;
    a0 = DIV_W'(q0);
    a1 = DIV_W'(q1);
    a2 = DIV_W'(q2);
    a3 = DIV_W'(q3);
    unique case (which)
      2'd0: begin
        n = a0 + (a1 <<< 2) + a2;
        m = (n + 40'sd3) >>> 1;
      end
      2'd1: begin
        n = (a1 <<< 1) + a2;
        m = n + 40'sd1;
      end
      2'd2: begin
        n = a1 + (a2 <<< 1);
        m = n + 40'sd1;
      end
      default: begin
        n = a1 + (a2 <<< 2) + a3;
        m = (n + 40'sd3) >>> 1;
      end
    endcase
    return dvd_t'(m) + DIV_OFS;
  endfunction

  // Multiply half of a lerp step
  function automatic logic signed [49:0] lerp_mul(input coord_t a, input coord_t b,
                                                  input logic [15:0] uf);
    logic signed [32:0] d;
    logic signed [49:0] de, ue;
    d  = 33'(b) - 33'(a);
    de = 50'(d);
    ue = 50'($signed({1'b0, uf}));
    return de * ue;
  endfunction

  // Round and add half of a lerp step
  function automatic coord_t lerp_add(input coord_t a, input logic signed [49:0] p);
    logic signed [49:0] t;
    t = (p + 50'sd32768) >>> 16;
    return a + t[31:0];
  endfunction

  // Sequencer, datapath registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
      lvl       <= '0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      total <= total_after;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            seg          <= t_segment;
            u            <= t_fraction;
            cnt          <= '0;
            curve_x      <= '0;
            curve_y      <= '0;
            period_count <= (total_after == '0) ? '0 : total_after + TOTAL_W'(2);
            if (command == CMD_EVAL && !eval_bad) begin
              state <= S_READ;
            end else begin
              if (command == CMD_APPEND && total == MAX_CNT) begin
                status <= ST_FULL;
              end else if (command == CMD_EVAL) begin
                status <= ST_RANGE;
              end else begin
                status <= ST_STORED;
              end
            end
          end
        end
        S_READ: begin
          if (cnt != 3'd0) begin
            qx[slot] <= rd_x;
            qy[slot] <= rd_y;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          for (int i = 0; i < 4; i++) begin
            dvd[i]     <= div_in(qx[0], qx[1], qx[2], qx[3], 2'(i));
            dvd[i + 4] <= div_in(qy[0], qy[1], qy[2], qy[3], 2'(i));
            rem[i]     <= '0;
            rem[i + 4] <= '0;
          end
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          for (int i = 0; i < 8; i++) begin
            rem[i] <= div3_rem({rem[i], dvd[i][DIV_W-1 -: 8]});
            quo[i] <= {quo[i][23:0], div3_quo({rem[i], dvd[i][DIV_W-1 -: 8]})};
            dvd[i] <= dvd[i] << 8;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'(DIV_STEPS - 1)) begin
            lvl   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // Quotients become Bezier points on the first level
          if (lvl == 2'd0) begin
            for (int i = 0; i < 4; i++) begin
              bx[i] <= quo[i];
              by[i] <= quo[i + 4];
            end
            for (int i = 0; i < 3; i++) begin
              prx[i] <= lerp_mul(quo[i], quo[i + 1], u);
              pry[i] <= lerp_mul(quo[i + 4], quo[i + 5], u);
            end
          end else begin
            for (int i = 0; i < 3; i++) begin
              prx[i] <= lerp_mul(bx[i], bx[i + 1], u);
              pry[i] <= lerp_mul(by[i], by[i + 1], u);
            end
          end
          state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 3; i++) begin
            bx[i] <= lerp_add(bx[i], prx[i]);
            by[i] <= lerp_add(by[i], pry[i]);
          end
          lvl <= lvl + 2'd1;
          state <= (lvl == 2'd2) ? S_DONE : S_MUL;
        end
        S_DONE: begin
          if (slot_free) begin
            curve_x   <= bx[0];
            curve_y   <= by[0];
            status    <= ST_EVAL;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/cbs_checker.sv
// Port-level checks for the cubic B-spline evaluator, bound to the top level.
// Depends on cbs_pkg and cubic_bspline_eval_2d_top.
module cbs_checker import cbs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] curve_x,
  input logic signed [31:0] curve_y,
  input logic [1:0]         status,
  input logic [12:0]        period_count
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(curve_x) && $stable(curve_y)
      && $stable(status) && $stable(period_count))
    else $error("result changed while stalled");

  // Only an evaluated item carries coordinates
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_EVAL |-> curve_x == 0 && curve_y == 0)
    else $error("nonzero curve on non-evaluate item");

  // An evaluation needs points loaded
  a_eval_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EVAL |-> period_count >= 13'd3)
    else $error("evaluation with empty store");

  // Period is zero or at least three
  a_period: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> period_count == 13'd0 || period_count >= 13'd3)
    else $error("bad period count");

endmodule

bind cubic_bspline_eval_2d_top cbs_checker u_cbs_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .curve_x(curve_x), .curve_y(curve_y), .status(status),
  .period_count(period_count)
);

### test/cubic_bspline_eval_2d_checker.sv
// Checker for the cubic B-spline evaluator: watches both channels, predicts
// each result from its own copy of the point store and compares field by field.
// Depends on cbs_pkg.
module cubic_bspline_eval_2d_checker import cbs_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic [11:0]        t_segment,
  input  logic [15:0]        t_fraction,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] curve_x,
  input  logic signed [31:0] curve_y,
  input  logic [1:0]         status,
  input  logic [12:0]        period_count,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [1:0]         st;
    logic [12:0]        period;
  } curve_res_t;

  longint     pts_x [MAX_POINTS];
  longint     pts_y [MAX_POINTS];
  int         n_pts;
  curve_res_t expected_q[$];

  // Round to nearest, ties upward
  function automatic longint rdiv(longint n, longint d);
    longint m;
    m = 2 * n + d;
    if (m >= 0) return m / (2 * d);
    return -((-m + 2 * d - 1) / (2 * d));
  endfunction

  function automatic longint lerp(longint a, longint b, longint u);
    return a + rdiv((b - a) * u, 65536);
  endfunction

  function automatic int clamp_idx(int p);
    if (p < 3) return 0;
    p -= 3;
    if (p >= n_pts) p = n_pts - 1;
    return p;
  endfunction

  function automatic logic signed [31:0] eval_axis(bit use_y, int seg, longint u);
    longint q[4];
    longint b0, b1, b2, b3, c0, c1, c2, d0, d1, r;
    for (int i = 0; i < 4; i++)
      q[i] = use_y ? pts_y[clamp_idx(seg + i)] : pts_x[clamp_idx(seg + i)];
    b0 = rdiv(q[0] + 4 * q[1] + q[2], 6);
    b1 = rdiv(2 * q[1] + q[2], 3);
    b2 = rdiv(q[1] + 2 * q[2], 3);
    b3 = rdiv(q[1] + 4 * q[2] + q[3], 6);
    c0 = lerp(b0, b1, u);
    c1 = lerp(b1, b2, u);
    c2 = lerp(b2, b3, u);
    d0 = lerp(c0, c1, u);
    d1 = lerp(c1, c2, u);
    r = lerp(d0, d1, u);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic curve_res_t predict_curve(logic [1:0] cmd, logic signed [31:0] px,
                                               logic signed [31:0] py, int seg, longint u);
    curve_res_t r;
    r = '0;
    r.st = ST_STORED;
    if (cmd == CMD_APPEND) begin
      if (n_pts >= MAX_POINTS) begin
        r.st = ST_FULL;
      end else begin
        pts_x[n_pts] = px;
        pts_y[n_pts] = py;
        n_pts++;
      end
    end else if (cmd == CMD_EVAL) begin
      if (n_pts == 0 || seg > n_pts + 2) begin
        r.st = ST_RANGE;
      end else begin
        r.x  = eval_axis(1'b0, seg, u);
        r.y  = eval_axis(1'b1, seg, u);
        r.st = ST_EVAL;
      end
    end else if (cmd == CMD_CLEAR) begin
      n_pts = 0;
    end
    r.period = (n_pts > 0) ? 13'(n_pts + 2) : 13'd0;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    n_pts = 0;
  end

  always @(posedge clk) begin
    curve_res_t e;
    curve_res_t pred;
    if (rst) begin
      n_pts = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected item status", status, -1);
        end else begin
          e = expected_q.pop_front();
          if (curve_x !== e.x) report("curve_x", curve_x, e.x);
          if (curve_y !== e.y) report("curve_y", curve_y, e.y);
          if (status !== e.st) report("status", status, e.st);
          if (period_count !== e.period) report("period_count", period_count, e.period);
        end
      end
      if (in_valid && in_ready) begin
        pred = predict_curve(command, point_x, point_y,
                             int'(t_segment), longint'(t_fraction));
        expected_q = {expected_q, pred};
      end
    end
    pending = expected_q.size();
  end
endmodule

### test/cubic_bspline_eval_2d_top_test.sv
// Testbench top for the cubic B-spline evaluator: drives directed and random
// items with random idling, gives the verdict. Depends on cbs_pkg, the block
// and cubic_bspline_eval_2d_checker.
module cubic_bspline_eval_2d_top_test import cbs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP = 256;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         command = CMD_APPEND;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic [11:0]        t_segment = '0;
  logic [15:0]        t_fraction = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] curve_x, curve_y;
  logic [1:0]         status;
  logic [12:0]        period_count;
  int                 fail_count, pending;
  int                 cycles = 0;
  int                 loaded = 0;
  int                 stall_left = 0;

  always #1 clk = ~clk;

  cubic_bspline_eval_2d_top #(.MAX_POINTS(MAXP)) dut (.*);

  cubic_bspline_eval_2d_checker #(.MAX_POINTS(MAXP)) chk (.*);

  // Gap length: mostly short, sometimes long
  function automatic int gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(40, 5);
    if ($urandom_range(2) == 0) return 0;
    return $urandom_range(3);
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(2 << 16))) - (1 <<< 16);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(logic [1:0] cmd, logic signed [31:0] px, logic signed [31:0] py,
                           logic [11:0] seg, logic [15:0] frac);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command    <= cmd;
    point_x    <= px;
    point_y    <= py;
    t_segment  <= seg;
    t_fraction <= frac;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (cmd == CMD_APPEND && loaded < MAXP) loaded++;
    if (cmd == CMD_CLEAR) loaded = 0;
  endtask

  task automatic rand_eval();
    logic [11:0] seg;
    if (loaded == 0 || $urandom_range(15) == 0) seg = 12'($urandom());
    else seg = 12'($urandom_range(loaded + 2));
    send_item(CMD_EVAL, $urandom(), $urandom(), seg, 16'($urandom()));
  endtask

  // Receiver: random stalls on the result channel, now and then a long one
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(60) == 0) begin
      stall_left <= $urandom_range(30, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(5) != 0) ? 1'b1 : 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty store, unused command, extremes, padding and range edges
    send_item(CMD_EVAL, '0, '0, 12'd0, 16'd0);
    send_item(CMD_UNUSED, 32'sh7FFF_FFFF, 32'sh8000_0000, 12'hFFF, 16'hFFFF);
    send_item(CMD_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000, 12'hFFF, 16'hFFFF);
    send_item(CMD_EVAL, '0, '0, 12'd3, 16'hFFFF);
    send_item(CMD_EVAL, '0, '0, 12'd4, 16'h0);
    send_item(CMD_APPEND, 32'sh8000_0000, 32'sh7FFF_FFFF, '0, '0);
    send_item(CMD_APPEND, 32'sh0001_0000, -32'sh0001_0000, '0, '0);
    for (int s = 0; s <= 6; s++)
      send_item(CMD_EVAL, '0, '0, 12'(s), (s % 2) ? 16'hFFFF : 16'h8000);
    send_item(CMD_EVAL, '0, '0, 12'hFFF, 16'h1);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_EVAL, '0, '0, 12'd0, 16'h0);
    // Fill the store, then overflow it
    for (int i = 0; i < MAXP; i++) send_item(CMD_APPEND, rand_coord(), rand_coord(), '0, '0);
    send_item(CMD_APPEND, 32'sh1234_5678, 32'sh1234_5678, '0, '0);
    send_item(CMD_EVAL, '0, '0, 12'(MAXP + 2), 16'hFFFF);
    send_item(CMD_EVAL, '0, '0, 12'(MAXP + 3), 16'h0);
    for (int i = 0; i < 60; i++) rand_eval();

    // Hold off until every result is back
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    // Random: short point lists loaded then evaluated, with some noise
    for (int blk = 0; blk < 120; blk++) begin
      send_item(CMD_CLEAR, $urandom(), $urandom(), 12'($urandom()), 16'($urandom()));
      repeat ($urandom_range(8, 1)) send_item(CMD_APPEND, rand_coord(), rand_coord(),
                                              12'($urandom()), 16'($urandom()));
      repeat ($urandom_range(8, 2)) begin
        case ($urandom_range(9))
          0: send_item(CMD_APPEND, rand_coord(), rand_coord(),
                       12'($urandom()), 16'($urandom()));
          1: send_item(CMD_UNUSED, $urandom(), $urandom(),
                       12'($urandom()), 16'($urandom()));
          default: rand_eval();
        endcase
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### cubic_bspline_eval_2d_top.f
hw/rtl/cbs_pkg.sv
hw/rtl/cbs_ram.sv
hw/rtl/cubic_bspline_eval_2d_top.sv
hw/rtl/cbs_checker.sv
test/cubic_bspline_eval_2d_checker.sv
test/cubic_bspline_eval_2d_top_test.sv
